/* src/sgmh_pkg.sv */
// Shared constants for the horizontal path cost aggregation block.
`timescale 1ns / 1ps
`default_nettype none

package sgmh_pkg;

    localparam int DEF_MAX_DISPARITY = 128;
    localparam int DEF_COST_BITS = 8;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DISPARITY_COUNT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENALTY_SMALL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PENALTY_LARGE = 2'd2;

    localparam logic [7:0] RST_DISPARITY_COUNT = 8'd64;
    localparam logic [7:0] RST_PENALTY_SMALL = 8'd10;
    localparam logic [11:0] RST_PENALTY_LARGE = 12'd120;

    localparam int PATH_BITS = 16;
    localparam logic [PATH_BITS-1:0] PATH_MAX = 16'hFFFF;

endpackage

`default_nettype wire

/* src/sgmh_cost_bank.sv */
// One copy of the double-banked path cost memory with a registered, write-first read port.
`timescale 1ns / 1ps
`default_nettype none

module sgmh_cost_bank #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    localparam int Depth = 2 ** ADDR_BITS;

    logic [DATA_BITS-1:0] mem [0:Depth-1];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read that hits the entry being written in the same cycle returns the new data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/sgm_horizontal_path_aggregation.sv */
// Top level of the semi-global matching cost aggregation along one scan path.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// cost      in         cost_valid/cost_stall    match_cost, row_start
// result    out        result_valid/result_stall path_cost, disparity_index, pixel_done
// cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// One request is taken every cycle unless stalled; it goes through the stage and result registers.
// The rate is set by the three copies of the cost memory, each read once per request.
// Reset sets the counters, minima and configuration to reset values; the memory is not cleared.
// The cost channel stalls only while the result register and the stage ahead of it are full
// and the result channel is stalled.
module sgm_horizontal_path_aggregation #(
    parameter int MAX_DISPARITY = sgmh_pkg::DEF_MAX_DISPARITY,
    parameter int COST_BITS = sgmh_pkg::DEF_COST_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cost_valid,
    output logic                                     cost_stall,
    input  wire logic [7:0]                          match_cost,
    input  wire logic                                row_start,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic [15:0]                              path_cost,
    output logic [6:0]                               disparity_index,
    output logic                                     pixel_done,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sgmh_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [sgmh_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    import sgmh_pkg::*;

    localparam int DW = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
    localparam int AW = DW + 1;
    localparam int CostUsed = (COST_BITS < 8) ? COST_BITS : 8;
    localparam logic [7:0] COST_MASK = 8'((1 << CostUsed) - 1);
    localparam logic [8:0] MAX_COUNT = 9'(MAX_DISPARITY);

    // Configuration registers.
    logic [7:0]  disparity_count_reg;
    logic [7:0]  penalty_small_reg;
    logic [11:0] penalty_large_reg;

    // Accept-side sequencing state.
    logic [DW-1:0] counter_reg;
    logic [DW-1:0] counter_next;
    logic          bank_reg;
    logic          bank_next;
    logic          first_reg;
    logic          first_next;

    // Stage between the memory read and the result register.
    logic          s1_valid_reg;
    logic [7:0]    s1_cost_reg;
    logic [DW-1:0] s1_d_reg;
    logic          s1_done_reg;
    logic          s1_first_reg;
    logic          s1_row_start_reg;
    logic          s1_bank_reg;
    logic          s1_use_lo_reg;
    logic          s1_use_hi_reg;

    // Minima along the path.
    logic [15:0] running_min_reg;
    logic [15:0] previous_min_reg;

    // Result register.
    logic          result_valid_reg;
    logic [15:0]   path_cost_reg;
    logic [6:0]    disparity_index_reg;
    logic          pixel_done_reg;

    logic          s2_load;
    logic          s1_load;
    logic          accept;
    logic          s1_fire;

    logic [7:0]    eff_count;
    logic [7:0]    eff_count_m1;
    logic [DW-1:0] start_count;
    logic          start_first;
    logic [DW-1:0] acc_d;
    logic          acc_done;
    logic          acc_use_lo;
    logic          acc_use_hi;
    logic [AW-1:0] rd_addr_lo;
    logic [AW-1:0] rd_addr_mid;
    logic [AW-1:0] rd_addr_hi;

    logic [15:0]   tap_lo;
    logic [15:0]   tap_mid;
    logic [15:0]   tap_hi;
    logic [16:0]   term_lo;
    logic [16:0]   term_hi;
    logic [16:0]   term_far;
    logic [16:0]   best_near;
    logic [16:0]   best_far;
    logic [16:0]   best;
    logic [16:0]   diff;
    logic [17:0]   sum;
    logic [15:0]   s1_val;
    logic [15:0]   run_base;
    logic [15:0]   run_new;
    logic [AW-1:0] wr_addr;

    // Handshake.
    assign s2_load = !result_valid_reg || !result_stall;
    assign s1_load = !s1_valid_reg || s2_load;
    assign accept = cost_valid && s1_load;
    assign s1_fire = s1_valid_reg && s2_load;
    assign cost_stall = !s1_load;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disparity_count_reg <= RST_DISPARITY_COUNT;
            penalty_small_reg <= RST_PENALTY_SMALL;
            penalty_large_reg <= RST_PENALTY_LARGE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DISPARITY_COUNT: disparity_count_reg <= cfg_data[7:0];
                CFG_PENALTY_SMALL:   penalty_small_reg <= cfg_data[7:0];
                CFG_PENALTY_LARGE:   penalty_large_reg <= cfg_data[11:0];
                default:             ;
            endcase
        end
    end

    // Disparity sequencing at acceptance.
    always_comb
    begin
        if (disparity_count_reg == 8'd0)
        begin
            eff_count = 8'd1;
        end
        else if ({1'b0, disparity_count_reg} > MAX_COUNT)
        begin
            eff_count = MAX_COUNT[7:0];
        end
        else
        begin
            eff_count = disparity_count_reg;
        end
        eff_count_m1 = eff_count - 8'd1;

        start_count = row_start ? '0 : counter_reg;
        start_first = row_start || first_reg;

        if (9'(start_count) >= {1'b0, eff_count})
        begin
            acc_d = eff_count_m1[DW-1:0];
        end
        else
        begin
            acc_d = start_count;
        end

        acc_done = (9'(acc_d) == {1'b0, eff_count_m1});
        acc_use_lo = (acc_d != '0);
        acc_use_hi = ((9'(acc_d) + 9'd1) < {1'b0, eff_count});

        if (acc_done)
        begin
            counter_next = '0;
            bank_next = !bank_reg;
            first_next = 1'b0;
        end
        else
        begin
            counter_next = acc_d + DW'(1);
            bank_next = bank_reg;
            first_next = start_first;
        end

        rd_addr_lo = {!bank_reg, acc_d - DW'(1)};
        rd_addr_mid = {!bank_reg, acc_d};
        rd_addr_hi = {!bank_reg, acc_d + DW'(1)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            bank_reg <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            counter_reg <= counter_next;
            bank_reg <= bank_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= cost_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cost_reg <= match_cost & COST_MASK;
            s1_d_reg <= acc_d;
            s1_done_reg <= acc_done;
            s1_first_reg <= start_first;
            s1_row_start_reg <= row_start;
            s1_bank_reg <= bank_reg;
            s1_use_lo_reg <= acc_use_lo;
            s1_use_hi_reg <= acc_use_hi;
        end
    end

    // Three copies of the cost memory give the three neighbor reads of each request.
    assign wr_addr = {s1_bank_reg, s1_d_reg};

    sgmh_cost_bank #(
        .ADDR_BITS(AW),
        .DATA_BITS(PATH_BITS)
    ) u_bank_lo (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (wr_addr),
        .wr_data (s1_val),
        .rd_en   (accept),
        .rd_addr (rd_addr_lo),
        .rd_data (tap_lo)
    );

    sgmh_cost_bank #(
        .ADDR_BITS(AW),
        .DATA_BITS(PATH_BITS)
    ) u_bank_mid (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (wr_addr),
        .wr_data (s1_val),
        .rd_en   (accept),
        .rd_addr (rd_addr_mid),
        .rd_data (tap_mid)
    );

    sgmh_cost_bank #(
        .ADDR_BITS(AW),
        .DATA_BITS(PATH_BITS)
    ) u_bank_hi (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (wr_addr),
        .wr_data (s1_val),
        .rd_en   (accept),
        .rd_addr (rd_addr_hi),
        .rd_data (tap_hi)
    );

    // Path cost update.
    always_comb
    begin
        term_lo = s1_use_lo_reg ? ({1'b0, tap_lo} + 17'(penalty_small_reg)) : 17'h1FFFF;
        term_hi = s1_use_hi_reg ? ({1'b0, tap_hi} + 17'(penalty_small_reg)) : 17'h1FFFF;
        term_far = {1'b0, previous_min_reg} + 17'(penalty_large_reg);

        best_near = (term_lo < term_hi) ? term_lo : term_hi;
        best_far = ({1'b0, tap_mid} < term_far) ? {1'b0, tap_mid} : term_far;
        best = (best_near < best_far) ? best_near : best_far;

        if (best >= {1'b0, previous_min_reg})
        begin
            diff = best - {1'b0, previous_min_reg};
        end
        else
        begin
            diff = '0;
        end

        sum = 18'(s1_cost_reg) + 18'(diff);

        if (s1_first_reg)
        begin
            s1_val = 16'(s1_cost_reg);
        end
        else if (sum > 18'(PATH_MAX))
        begin
            s1_val = PATH_MAX;
        end
        else
        begin
            s1_val = sum[15:0];
        end

        run_base = s1_row_start_reg ? PATH_MAX : running_min_reg;
        run_new = (s1_val < run_base) ? s1_val : run_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_min_reg <= PATH_MAX;
            previous_min_reg <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_done_reg)
            begin
                previous_min_reg <= run_new;
                running_min_reg <= PATH_MAX;
            end
            else
            begin
                running_min_reg <= run_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            result_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            path_cost_reg <= s1_val;
            disparity_index_reg <= 7'(s1_d_reg);
            pixel_done_reg <= s1_done_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign path_cost = path_cost_reg;
    assign disparity_index = disparity_index_reg;
    assign pixel_done = pixel_done_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        cost_stall |-> (s1_valid_reg && result_valid_reg))
    else $error("Cost channel stalled while the pipeline has room.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> result_valid_reg)
    else $error("A request left the compute stage without reaching the result register.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_done) |=> (!first_reg && (counter_reg == '0)))
    else $error("Pixel completion did not restart the disparity sequence.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_done_reg) |=> (running_min_reg == PATH_MAX))
    else $error("Running minimum was not cleared at the end of a pixel.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && acc_done) |=> (bank_reg != $past(bank_reg)))
    else $error("Cost banks did not swap at the end of a pixel.");
`endif

endmodule

`default_nettype wire

/* tb/tb_sgm_horizontal_path_aggregation.sv */
// Self-checking testbench for the horizontal path cost aggregation block.
`timescale 1ns / 1ps

module tb_sgm_horizontal_path_aggregation;

    import sgmh_pkg::*;

    localparam int MAXD = DEF_MAX_DISPARITY;
    localparam int COST_MASK = ((1 << DEF_COST_BITS) - 1) & 8'hFF;
    localparam int QUIET_LIMIT = 3000;
    localparam int PHASES = 12;
    localparam int PHASE_BUDGET = 100;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic [7:0] cost;
        logic       row;
    } cost_req_t;

    typedef struct packed {
        logic [15:0] path_cost;
        logic [6:0]  disparity_index;
        logic        pixel_done;
    } path_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cost_valid = 1'b0;
    wire logic                 cost_stall;
    logic [7:0]                match_cost = '0;
    logic                      row_start = 1'b0;
    wire logic                 result_valid;
    logic                      result_stall = 1'b0;
    wire logic [15:0]          path_cost;
    wire logic [6:0]           disparity_index;
    wire logic                 pixel_done;
    logic                      cfg_valid = 1'b0;
    wire logic                 cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    sgm_horizontal_path_aggregation uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cost_valid      (cost_valid),
        .cost_stall      (cost_stall),
        .match_cost      (match_cost),
        .row_start       (row_start),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .path_cost       (path_cost),
        .disparity_index (disparity_index),
        .pixel_done      (pixel_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cost_req_t    pending_costs[$];
    path_result_t expected_paths[$];
    cost_req_t    next_req;
    path_result_t want;

    logic [15:0] path_bank [2][MAXD];
    logic [15:0] prev_min;
    logic [15:0] run_min;
    logic [6:0]  disp_ctr;
    logic        bank_sel;
    logic        first_px;
    logic [7:0]  disp_count_reg;
    logic [7:0]  p_small_reg;
    logic [11:0] p_large_reg;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count = 0;
    int n_requests = 0;
    int n_results = 0;
    int n_settings = 0;
    int quiet_cycles = 0;

    function automatic int eff_count(input logic [7:0] v);
        if (v == 8'd0)
            return 1;
        if (int'(v) > MAXD)
            return MAXD;
        return int'(v);
    endfunction

    task automatic aggregate_path(input logic [7:0] cost_in, input logic row_in);
        int cnt;
        int d;
        int best;
        int term;
        int pm;
        int val;
        logic nb;
        path_result_t res;
        cnt = eff_count(disp_count_reg);
        if (row_in)
        begin
            disp_ctr = '0;
            first_px = 1'b1;
            run_min = PATH_MAX;
        end
        d = int'(disp_ctr);
        if (d >= cnt)
            d = cnt - 1;
        if (first_px)
        begin
            val = int'(cost_in) & COST_MASK;
        end
        else
        begin
            nb = ~bank_sel;
            pm = int'(prev_min);
            best = int'(path_bank[nb][d]);
            if (d > 0)
            begin
                term = int'(path_bank[nb][d-1]) + int'(p_small_reg);
                if (term < best)
                    best = term;
            end
            if (d + 1 < cnt)
            begin
                term = int'(path_bank[nb][d+1]) + int'(p_small_reg);
                if (term < best)
                    best = term;
            end
            term = pm + int'(p_large_reg);
            if (term < best)
                best = term;
            val = (int'(cost_in) & COST_MASK) + ((best >= pm) ? best - pm : 0);
            if (val > int'(PATH_MAX))
                val = int'(PATH_MAX);
        end
        path_bank[bank_sel][d] = val[15:0];
        if (val[15:0] < run_min)
            run_min = val[15:0];
        res.path_cost = val[15:0];
        res.disparity_index = d[6:0];
        res.pixel_done = (d + 1 == cnt);
        if (res.pixel_done)
        begin
            prev_min = run_min;
            run_min = PATH_MAX;
            bank_sel = ~bank_sel;
            first_px = 1'b0;
            disp_ctr = '0;
        end
        else
        begin
            disp_ctr = 7'(d + 1);
        end
        expected_paths.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_valid <= 1'b0;
            match_cost <= '0;
            row_start <= 1'b0;
        end
        else
        begin
            if (cost_valid && !cost_stall)
            begin
                aggregate_path(match_cost, row_start);
                n_requests++;
            end
            if (!cost_valid || !cost_stall)
            begin
                if (pending_costs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = pending_costs.pop_front();
                    cost_valid <= 1'b1;
                    match_cost <= next_req.cost;
                    row_start <= next_req.row;
                end
                else
                begin
                    cost_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                n_results++;
                if (expected_paths.size() == 0)
                begin
                    $error("result with no request pending: path_cost %0d", path_cost);
                    err_count++;
                end
                else
                begin
                    want = expected_paths.pop_front();
                    if (path_cost !== want.path_cost)
                    begin
                        $error("path_cost: expected %0d, got %0d", want.path_cost, path_cost);
                        err_count++;
                    end
                    if (disparity_index !== want.disparity_index)
                    begin
                        $error("disparity_index: expected %0d, got %0d",
                               want.disparity_index, disparity_index);
                        err_count++;
                    end
                    if (pixel_done !== want.pixel_done)
                    begin
                        $error("pixel_done: expected %0d, got %0d", want.pixel_done, pixel_done);
                        err_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cost_valid && !cost_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("sgm_horizontal_path_aggregation: mismatch");
        $finish;
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_DISPARITY_COUNT: disp_count_reg = val[7:0];
            CFG_PENALTY_SMALL:   p_small_reg = val[7:0];
            CFG_PENALTY_LARGE:   p_large_reg = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [11:0] count_val, input logic [11:0] small_val,
                             input logic [11:0] large_val);
        @(posedge clk);
        write_reg(CFG_DISPARITY_COUNT, count_val);
        write_reg(CFG_PENALTY_SMALL, small_val);
        write_reg(CFG_PENALTY_LARGE, large_val);
        cfg_valid <= 1'b0;
        n_settings++;
        @(negedge clk);
    endtask

    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (pending_costs.size() != 0 || cost_valid || expected_paths.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_item(input logic [7:0] cost, input logic row);
        cost_req_t req;
        req.cost = cost;
        req.row = row;
        pending_costs.push_back(req);
    endtask

    // A row of whole pixels with one style of cost content; now and then it is cut
    // short or gets a stray row start in the middle.
    task automatic queue_row(input int cnt, input bit starts, output int pushed);
        int npix;
        int style;
        int total;
        int i;
        logic [7:0] c;
        logic r;
        npix = (cnt > 32) ? $urandom_range(3, 2) : $urandom_range(6, 1);
        style = $urandom_range(2);
        c = 8'($urandom);
        total = npix * cnt;
        if (total > 1 && $urandom_range(9) == 0)
            total = $urandom_range(total - 1, 1);
        for (i = 0; i < total; i++)
        begin
            case (style)
                0: c = 8'($urandom);
                1: c = $urandom_range(1) ? 8'hFF : 8'h00;
                default: c = 8'(c + $urandom_range(6) - 3);
            endcase
            r = (i == 0) && starts;
            if ($urandom_range(199) == 0)
                r = 1'b1;
            queue_item(c, r);
        end
        pushed = total;
    endtask

    int phase_counts [PHASES] = '{6, 255, 2, 13, 1, 100, 9, 40, 4, 64, 3, 16};

    initial
    begin
        int ph;
        int added;
        int pushed;
        int new_eff;
        bit carry_on;
        bit first_row;
        logic [11:0] small_val;
        logic [11:0] large_val;
        logic [3:0] junk;

        foreach (path_bank[b, e])
            path_bank[b][e] = '0;
        prev_min = '0;
        run_min = PATH_MAX;
        disp_ctr = '0;
        bank_sel = 1'b0;
        first_px = 1'b1;
        disp_count_reg = RST_DISPARITY_COUNT;
        p_small_reg = RST_PENALTY_SMALL;
        p_large_reg = RST_PENALTY_LARGE;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 16;
        recv_idle_pct = 88;

        // Settings from reset, and a first request with no row start.
        queue_row(eff_count(disp_count_reg), 1'b0, pushed);
        drain();

        // A count of zero acts as one level, with the largest penalties.
        configure(12'h000, 12'h0FF, 12'hFFF);
        queue_item(8'd0, 1'b1);
        queue_item(8'd255, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(8'd0, 1'b0);
        drain();

        // Upper data bits are dropped; zero penalties; a row start in mid pixel.
        configure(12'hF03, 12'hA00, 12'h000);
        queue_item(8'd255, 1'b1);
        queue_item(8'd0, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(8'd0, 1'b0);
        queue_item(8'd255, 1'b0);
        queue_item(8'd7, 1'b1);
        queue_item(8'd9, 1'b0);
        queue_item(8'd200, 1'b0);
        queue_item(8'd3, 1'b0);
        queue_item(8'd4, 1'b0);
        queue_item(8'd5, 1'b0);
        drain();

        // The count is lowered while a pixel is half done.
        configure(12'd4, 12'd10, 12'd40);
        queue_item(8'd1, 1'b1);
        queue_item(8'd2, 1'b0);
        queue_item(8'd3, 1'b0);
        queue_item(8'd4, 1'b0);
        queue_item(8'd50, 1'b0);
        queue_item(8'd60, 1'b0);
        drain();
        @(posedge clk);
        write_reg(CFG_DISPARITY_COUNT, 12'd2);
        write_reg(CFG_UNUSED_INDEX, 12'($urandom));
        cfg_valid <= 1'b0;
        n_settings++;
        @(negedge clk);
        queue_item(8'd70, 1'b0);
        queue_item(8'd80, 1'b0);
        queue_item(8'd90, 1'b0);
        drain();

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 88;
                recv_idle_pct = 16;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            new_eff = eff_count(8'(phase_counts[ph]));
            carry_on = (new_eff <= eff_count(disp_count_reg)) && ($urandom_range(1) == 1);
            case (ph % 4)
                0: small_val = 12'd0;
                1: small_val = 12'd255;
                2: small_val = 12'($urandom_range(40));
                default: small_val = 12'($urandom_range(4095));
            endcase
            case (ph % 3)
                0: large_val = 12'd4095;
                1: large_val = 12'd0;
                default: large_val = 12'($urandom_range(400));
            endcase
            junk = 4'($urandom);
            configure({junk, 8'(phase_counts[ph])}, small_val, large_val);
            added = 0;
            first_row = 1'b1;
            while (added < PHASE_BUDGET)
            begin
                queue_row(new_eff, !(first_row && carry_on), pushed);
                added += pushed;
                first_row = 1'b0;
            end
            drain();
        end

        repeat (10) @(negedge clk);
        $display("Ran %0d cost requests and checked %0d path results over %0d settings,",
                 n_requests, n_results, n_settings);
        $display("with stalls on either side, row restarts and count changes mid pixel.");
        if (err_count == 0 && expected_paths.size() == 0)
            $display("sgm_horizontal_path_aggregation: match");
        else
            $display("sgm_horizontal_path_aggregation: mismatch");
        $finish;
    end

endmodule

/* sgm_horizontal_path_aggregation.f */
src/sgmh_pkg.sv
src/sgmh_cost_bank.sv
src/sgm_horizontal_path_aggregation.sv
tb/tb_sgm_horizontal_path_aggregation.sv
